FILE: rtl/fppa_pkg.sv
// Shared types and constants for the fixed page pool allocator.
// No dependencies; imported by every module of the block.
package fppa_pkg;

  localparam int PAGE_SLOTS = 256;
  localparam int ALIGN      = 16;
  localparam int HW_SLOTS   = 256;

  localparam int IDX_W    = 8;
  localparam int CNT_W    = 9;
  localparam int PB_W     = 17;
  localparam int STRIDE_W = 17;
  localparam int OFF_W    = 24;
  localparam int PROD_W   = 25;
  localparam int LIMIT_W  = 25;
  localparam int OUT_W    = 40;

  localparam logic [PB_W-1:0]     RESET_PAGE_BYTES = PB_W'(64);
  localparam logic [STRIDE_W-1:0] RESET_STRIDE     =
    STRIDE_W'(((64 + ALIGN - 1) / ALIGN) * ALIGN);

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CAPACITY = 2'd1,
    ST_RANGE    = 2'd2,
    ST_DOUBLE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_PAGE_BYTES = 2'd0,
    REG_MAX_PAGES  = 2'd1,
    REG_INIT_PAGES = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [STRIDE_W-1:0] stride;
    logic                create_ok;
  } geo_t;

endpackage

FILE: rtl/fppa_stack_ram.sv
// Free stack storage: 256 x 8 single-write, single-read synchronous RAM.
// Read data registered. Uses fppa_pkg.
module fppa_stack_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [fppa_pkg::IDX_W-1:0] wr_addr,
  input  logic [fppa_pkg::IDX_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [fppa_pkg::IDX_W-1:0] rd_addr,
  output logic [fppa_pkg::IDX_W-1:0] rd_data
);
  import fppa_pkg::*;

  logic [IDX_W-1:0] mem_r [HW_SLOTS];
  logic [IDX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/fppa_geom.sv
// Page geometry: aligned stride, arena limit and the page creation check.
// Stride and limit are registered from the config registers. Uses fppa_pkg.
module fppa_geom (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fppa_pkg::PB_W-1:0]     page_bytes,
  input  logic [fppa_pkg::CNT_W-1:0]    max_pages,
  input  logic [fppa_pkg::CNT_W-1:0]    pages_created,
  input  logic [fppa_pkg::LIMIT_W-1:0]  next_off,
  output fppa_pkg::geo_t                geo
);
  import fppa_pkg::*;

  logic [STRIDE_W-1:0] stride_r, stride_nxt;
  logic [LIMIT_W-1:0]  limit_r, limit_nxt;
  logic [PB_W:0]       pb_round;
  logic [LIMIT_W:0]    need;
  logic                fit;
  logic                under_max;
  logic                under_slots;

  always_comb begin
    pb_round   = {1'b0, page_bytes} + (PB_W+1)'(ALIGN - 1);
    stride_nxt = STRIDE_W'((pb_round / ALIGN) * ALIGN);
    limit_nxt  = LIMIT_W'({16'b0, max_pages} * {8'b0, page_bytes});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= RESET_STRIDE;
      limit_r  <= '0;
    end else begin
      stride_r <= stride_nxt;
      limit_r  <= limit_nxt;
    end
  end

  always_comb begin
    need        = {1'b0, next_off} + (LIMIT_W+1)'(page_bytes);
    fit         = need <= {1'b0, limit_r};
    under_max   = pages_created < max_pages;
    under_slots = int'(pages_created) < PAGE_SLOTS;
    geo.stride  = stride_r;
    geo.create_ok = (page_bytes != '0) && (int'(pages_created) < HW_SLOTS) &&
                    ((max_pages != '0) ? (under_max && fit) : under_slots);
  end

endmodule

FILE: rtl/fixed_page_pool_allocator_core.sv
// Fixed page pool allocator: LIFO free stack and free marks in two RAMs, control.
// Result registered when EXEC completes; EXEC waits while the output is held.
// One item at a time, as the free stack and mark RAM are read ahead of the update.
// Reset: page size 64, no limit, empty pool. A config write to one of the three
// registers restarts the pool and blocks input while pages are pre-created.
// A mark is written whenever its page is created, so restart needs no clearing pass.
module fixed_page_pool_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] page_index
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [1:0] status, [9:2] page_out, [33:10] byte_offset
  output logic        out_tuser,  // [0] setup_error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import fppa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_SETUP = 4'b0100,
    S_FILL  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [PB_W-1:0]      pb_r;
  logic [CNT_W-1:0]     mp_r, ip_r;
  logic [1:0]           op_r;
  logic [IDX_W-1:0]     pi_r;
  logic [CNT_W-1:0]     pc_r, pc_nxt;
  logic [CNT_W-1:0]     fc_r, fc_nxt;
  logic                 failed_r, failed_nxt;
  logic [LIMIT_W-1:0]   next_off_r, next_off_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [IDX_W-1:0]     out_page_r, out_page_nxt;
  logic [OFF_W-1:0]     out_off_r, out_off_nxt;
  logic                 out_err_r, out_err_nxt;

  logic                 mark_mem_r [HW_SLOTS];
  logic                 mark_rd_r;
  logic                 mark_we, mark_wd;
  logic [IDX_W-1:0]     mark_wa;

  logic                 in_xfer, cfg_xfer, cfg_restart;
  logic                 wr_en, rd_en;
  logic [IDX_W-1:0]     wr_data, rd_data;
  logic [IDX_W-1:0]     mul_k;
  logic [PROD_W-1:0]    prod;
  geo_t                 geo;

  assign in_tready   = (state_r == S_IDLE);
  assign cfg_ready   = 1'b1;
  assign in_xfer     = in_tvalid && in_tready;
  assign cfg_xfer    = cfg_valid && cfg_ready;
  assign cfg_restart = cfg_xfer && ((cfg_index == REG_PAGE_BYTES) ||
                       (cfg_index == REG_MAX_PAGES) || (cfg_index == REG_INIT_PAGES));

  fppa_stack_ram u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fc_r[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (IDX_W'(fc_r - CNT_W'(1))),
    .rd_data (rd_data)
  );

  fppa_geom u_geom (
    .clk           (clk),
    .rst_n         (rst_n),
    .page_bytes    (pb_r),
    .max_pages     (mp_r),
    .pages_created (pc_r),
    .next_off      (next_off_r),
    .geo           (geo)
  );

  assign prod = {{(PROD_W-IDX_W){1'b0}}, mul_k} * {{(PROD_W-STRIDE_W){1'b0}}, geo.stride};

  // free marks, read at the request index on input transfer
  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem_r[mark_wa] <= mark_wd;
    end
    if (rd_en) begin
      mark_rd_r <= mark_mem_r[in_tdata];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_r <= RESET_PAGE_BYTES;
      mp_r <= '0;
      ip_r <= '0;
    end else if (cfg_xfer) begin
      case (cfg_index)
        REG_PAGE_BYTES: pb_r <= cfg_data;
        REG_MAX_PAGES:  mp_r <= cfg_data[CNT_W-1:0];
        REG_INIT_PAGES: ip_r <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r <= in_tuser;
      pi_r <= in_tdata;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    pc_nxt         = pc_r;
    fc_nxt         = fc_r;
    failed_nxt     = failed_r;
    next_off_nxt   = next_off_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_off_nxt    = out_off_r;
    out_err_nxt    = out_err_r;
    wr_en          = 1'b0;
    wr_data        = pi_r;
    rd_en          = 1'b0;
    mul_k          = pi_r;
    mark_we        = 1'b0;
    mark_wa        = pi_r;
    mark_wd        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          rd_en     = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_page_nxt   = pi_r;
          out_off_nxt    = '0;
          out_err_nxt    = failed_r;
          state_nxt      = S_IDLE;
          case (op_r)
            OP_ALLOC: begin
              if (fc_r != '0) begin
                mul_k        = rd_data;
                fc_nxt       = fc_r - CNT_W'(1);
                mark_we      = 1'b1;
                mark_wa      = rd_data;
                mark_wd      = 1'b0;
                out_page_nxt = rd_data;
                out_off_nxt  = prod[OFF_W-1:0];
              end else if (geo.create_ok) begin
                mul_k        = pc_r[IDX_W-1:0];
                pc_nxt       = pc_r + CNT_W'(1);
                next_off_nxt = next_off_r + LIMIT_W'(geo.stride);
                mark_we      = 1'b1;
                mark_wa      = pc_r[IDX_W-1:0];
                mark_wd      = 1'b0;
                out_page_nxt = pc_r[IDX_W-1:0];
                out_off_nxt  = prod[OFF_W-1:0];
              end else begin
                out_status_nxt = ST_CAPACITY;
                out_page_nxt   = '0;
              end
            end
            OP_FREE: begin
              if ({1'b0, pi_r} >= pc_r) begin
                out_status_nxt = ST_RANGE;
              end else if (mark_rd_r) begin
                out_status_nxt = ST_DOUBLE;
              end else begin
                wr_en   = 1'b1;
                fc_nxt  = fc_r + CNT_W'(1);
                mark_we = 1'b1;
                mark_wa = pi_r;
                mark_wd = 1'b1;
              end
            end
            OP_LOOKUP: begin
              if ({1'b0, pi_r} >= pc_r) begin
                out_status_nxt = ST_RANGE;
              end else begin
                out_off_nxt = prod[OFF_W-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SETUP: begin
        if ((pb_r == '0) || ((mp_r != '0) && (ip_r > mp_r))) begin
          failed_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        if (pc_r == ip_r) begin
          state_nxt = S_IDLE;
        end else if (geo.create_ok) begin
          wr_en        = 1'b1;
          wr_data      = pc_r[IDX_W-1:0];
          mark_we      = 1'b1;
          mark_wa      = pc_r[IDX_W-1:0];
          mark_wd      = 1'b1;
          pc_nxt       = pc_r + CNT_W'(1);
          fc_nxt       = fc_r + CNT_W'(1);
          next_off_nxt = next_off_r + LIMIT_W'(geo.stride);
        end else begin
          failed_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_restart) begin
      state_nxt    = S_SETUP;
      pc_nxt       = '0;
      fc_nxt       = '0;
      failed_nxt   = 1'b0;
      next_off_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      fc_r        <= '0;
      failed_r    <= 1'b0;
      next_off_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      fc_r        <= fc_nxt;
      failed_r    <= failed_nxt;
      next_off_r  <= next_off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_off_r    <= out_off_nxt;
    out_err_r    <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W-OFF_W-IDX_W-2)'(0), out_off_r, out_page_r, out_status_r};
  assign out_tuser  = out_err_r;

endmodule
